// ===== sv/bqbp_pkg.sv =====
// Shared types, widths and register codes for the band-pass biquad block.
`timescale 1ns / 1ps

package bqbp_pkg;

  localparam int unsigned SampleWidth = 24;
  localparam int unsigned CoefWidth   = 26;
  localparam int unsigned GainWidth   = 24;
  localparam int unsigned DelayWidth  = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [GainWidth-1:0] GainReset = 24'd1048576;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic        [GainWidth-1:0]   gain_t;
  typedef logic signed [DelayWidth-1:0]  delay_t;
  typedef logic        [CoefWidth-1:0]   cfg_data_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COEF_A1  = 2'd0,
    REG_COEF_A2  = 2'd1,
    REG_COEF_B0  = 2'd2,
    REG_OUT_GAIN = 2'd3
  } cfg_reg_e;

endpackage

// ===== sv/bqbp_if.sv =====
// Handshake channel interfaces for samples in, samples out and register writes.
`timescale 1ns / 1ps

interface bqbp_in_if;
  logic             valid;
  logic             ready;
  bqbp_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqbp_out_if;
  logic             valid;
  logic             ready;
  bqbp_pkg::sample_t sample_out;
  logic             clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface bqbp_cfg_if;
  logic                 valid;
  logic                 ready;
  bqbp_pkg::cfg_reg_e   index;
  bqbp_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/biquad_bandpass_filter.sv =====
// Band-pass biquad in direct form II with output gain, built on one shared multiplier.
`timescale 1ns / 1ps

// Usage
// in_i carries one signed Q1.23 sample per word; out_o returns one filtered word
// (sample_out and the clipped flag) for every sample taken. cfg_i writes the four
// coefficient and gain registers and is always ready; write it only while idle.
// Each sample runs through a sequencer that drives a single 38 x 26 bit signed
// multiplier four times (a1*w1, a2*w2, b0*(w - w2), v*gain), with a register
// after every product. A sample is taken in the idle state, and its word is loaded
// into the output register in the last step; in_i.ready is low until then, so a
// new sample is taken only after the last word has gone into the output register.
// A finished word sits in the output register, and the next sample is accepted
// meanwhile. If the receiver still holds off the earlier word when the next one
// is done, the sequencer waits in its last step until out_o is free.
// Reset clears both delay values, sets a1, a2 and b0 to zero and the gain to
// unity, and empties the output register.

module biquad_bandpass_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  bqbp_in_if.sink             in_i,
  bqbp_out_if.source          out_o,
  bqbp_cfg_if.sink            cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A1,
    S_MUL_A2,
    S_ACC_A2,
    S_W_SAT,
    S_MUL_B0,
    S_V_RND,
    S_MUL_G,
    S_Y_OUT
  } state_e;

  localparam logic signed [60:0] RoundW = 61'sd2097152;
  localparam logic signed [63:0] RoundV = 64'sd2097152;
  localparam logic signed [63:0] RoundY = 64'sd524288;

  state_e                state_q;
  bqbp_pkg::coef_t       coef_a1_q;
  bqbp_pkg::coef_t       coef_a2_q;
  bqbp_pkg::coef_t       coef_b0_q;
  bqbp_pkg::gain_t       out_gain_q;
  bqbp_pkg::delay_t      delay_one_q;
  bqbp_pkg::delay_t      delay_two_q;
  bqbp_pkg::delay_t      w_q;
  logic signed [60:0]    acc_q;
  logic signed [37:0]    v_q;
  logic signed [63:0]    prod_q;
  logic                  hit_q;
  logic                  out_valid_q;
  bqbp_pkg::sample_t     sample_out_q;
  logic                  clipped_q;

  logic signed [37:0]    mul_a;
  logic signed [25:0]    mul_b;
  logic signed [63:0]    prod_d;
  logic signed [60:0]    w_full;
  logic                  w_ovf;
  bqbp_pkg::delay_t      w_d;
  logic signed [63:0]    v_full;
  logic signed [63:0]    y_full;
  logic                  y_ovf;
  bqbp_pkg::sample_t     y_d;
  logic signed [32:0]    w_diff;
  logic                  out_free;

  assign cfg_i.ready      = 1'b1;
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;
  assign out_o.clipped    = clipped_q;
  assign out_free         = !out_valid_q || out_o.ready;

  // Operand selection for the shared multiplier.
  assign w_diff = 33'(w_q) - 33'(delay_two_q);

  always_comb begin
    unique case (state_q)
      S_MUL_A1: begin
        mul_a = 38'(delay_one_q);
        mul_b = coef_a1_q;
      end
      S_MUL_A2: begin
        mul_a = 38'(delay_two_q);
        mul_b = coef_a2_q;
      end
      S_MUL_B0: begin
        mul_a = 38'(w_diff);
        mul_b = coef_b0_q;
      end
      S_MUL_G: begin
        mul_a = v_q;
        mul_b = $signed({2'b00, out_gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Feedback sum rounded to Q9.23 and clamped to the 32-bit delay range.
  assign w_full = (acc_q + RoundW) >>> 22;
  assign w_ovf  = !((&w_full[60:31]) || !(|w_full[60:31]));
  assign w_d    = w_ovf ? (w_full[60] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_full[31:0];

  assign v_full = (prod_q + RoundV) >>> 22;

  // Gained output rounded to Q1.23 and clamped to the sample range.
  assign y_full = (prod_q + RoundY) >>> 20;
  assign y_ovf  = !((&y_full[63:23]) || !(|y_full[63:23]));
  assign y_d    = y_ovf ? (y_full[63] ? 24'sh80_0000 : 24'sh7F_FFFF) : y_full[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
      coef_b0_q   <= '0;
      out_gain_q  <= bqbp_pkg::GainReset;
      delay_one_q <= '0;
      delay_two_q <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          bqbp_pkg::REG_COEF_A1:  coef_a1_q  <= cfg_i.data;
          bqbp_pkg::REG_COEF_A2:  coef_a2_q  <= cfg_i.data;
          bqbp_pkg::REG_COEF_B0:  coef_b0_q  <= cfg_i.data;
          bqbp_pkg::REG_OUT_GAIN: out_gain_q <= cfg_i.data[bqbp_pkg::GainWidth-1:0];
          default: ;
        endcase
      end

      // In the final step the output register is reloaded below instead.
      if (out_valid_q && out_o.ready && (state_q != S_Y_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            acc_q   <= {{15{in_i.sample_in[23]}}, in_i.sample_in, 22'b0};
            hit_q   <= 1'b0;
            state_q <= S_MUL_A1;
          end
        end
        S_MUL_A1: begin
          prod_q  <= prod_d;
          state_q <= S_MUL_A2;
        end
        S_MUL_A2: begin
          acc_q   <= acc_q - prod_q[60:0];
          prod_q  <= prod_d;
          state_q <= S_ACC_A2;
        end
        S_ACC_A2: begin
          acc_q   <= acc_q - prod_q[60:0];
          state_q <= S_W_SAT;
        end
        S_W_SAT: begin
          w_q     <= w_d;
          hit_q   <= w_ovf;
          state_q <= S_MUL_B0;
        end
        S_MUL_B0: begin
          prod_q  <= prod_d;
          state_q <= S_V_RND;
        end
        S_V_RND: begin
          v_q     <= v_full[37:0];
          state_q <= S_MUL_G;
        end
        S_MUL_G: begin
          prod_q  <= prod_d;
          state_q <= S_Y_OUT;
        end
        S_Y_OUT: begin
          if (out_free) begin
            sample_out_q <= y_d;
            clipped_q    <= hit_q || y_ovf;
            out_valid_q  <= 1'b1;
            delay_two_q  <= delay_one_q;
            delay_one_q  <= w_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A sample taken starts the sequence, so no second one can follow at once.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted again while the sequencer was busy");

  // A new word only appears out of the final step of the sequence.
  a_word_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_Y_OUT))
    else $error("output word raised outside the final step");

  // The delay line only moves when a word is handed to the output register.
  a_delay_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(delay_two_q) |-> $past(state_q == S_Y_OUT) && out_o.valid)
    else $error("delay values changed without producing a word");
`endif

endmodule

// ===== tb/bqbp_out_checker.sv =====
// Output checker for the band-pass biquad: tracks registers and delays, predicts and compares words.
`timescale 1ns / 1ps

module bqbp_out_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bqbp_in_if          in_ch,
  bqbp_out_if         out_ch,
  bqbp_cfg_if         cfg_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam longint RoundQ22  = 64'sd2097152;
  localparam longint RoundQ20  = 64'sd524288;
  localparam longint DelayMax  = 64'sd2147483647;
  localparam longint DelayMin  = -64'sd2147483648;
  localparam longint SampleMax = 64'sd8388607;
  localparam longint SampleMin = -64'sd8388608;

  typedef struct packed {
    bqbp_pkg::sample_t sample_out;
    logic              clipped;
  } out_word_t;

  typedef struct {
    longint    delay;
    out_word_t word;
  } filter_step_t;

  bqbp_pkg::coef_t a1_q;
  bqbp_pkg::coef_t a2_q;
  bqbp_pkg::coef_t b0_q;
  bqbp_pkg::gain_t gain_q;
  longint          delay_one_q;
  longint          delay_two_q;
  out_word_t       expected_words[$];
  int unsigned     fails;

  // One sample through the filter with the current registers and delays.
  function automatic filter_step_t filter_step(input bqbp_pkg::sample_t x);
    longint       acc;
    longint       w;
    longint       v;
    longint       y;
    logic         hit;
    filter_step_t r;
    hit = 1'b0;
    acc = (longint'(x) <<< 22) - longint'(a1_q) * delay_one_q
          - longint'(a2_q) * delay_two_q;
    w = (acc + RoundQ22) >>> 22;
    if (w > DelayMax) begin
      w   = DelayMax;
      hit = 1'b1;
    end else if (w < DelayMin) begin
      w   = DelayMin;
      hit = 1'b1;
    end
    // The numerator term is kept at full width before the gain is applied.
    v = (longint'(b0_q) * (w - delay_two_q) + RoundQ22) >>> 22;
    y = (v * longint'(gain_q) + RoundQ20) >>> 20;
    if (y > SampleMax) begin
      y   = SampleMax;
      hit = 1'b1;
    end else if (y < SampleMin) begin
      y   = SampleMin;
      hit = 1'b1;
    end
    r.delay           = w;
    r.word.sample_out = y[bqbp_pkg::SampleWidth-1:0];
    r.word.clipped    = hit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t    exp_w;
    filter_step_t nxt;
    if (!rst_ni) begin
      a1_q        = '0;
      a2_q        = '0;
      b0_q        = '0;
      gain_q      = bqbp_pkg::GainReset;
      delay_one_q = 0;
      delay_two_q = 0;
      fails       = 0;
      expected_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Outputs are matched first so that a stray word never takes the
      // expectation of a sample accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("sample_out word with no expectation waiting: actual %0d",
                 out_ch.sample_out);
          fails++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.sample_out !== exp_w.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   exp_w.sample_out, out_ch.sample_out);
            fails++;
          end
          if (out_ch.clipped !== exp_w.clipped) begin
            $error("clipped mismatch: expected %0d, actual %0d",
                   exp_w.clipped, out_ch.clipped);
            fails++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          bqbp_pkg::REG_COEF_A1:  a1_q   = bqbp_pkg::coef_t'(cfg_ch.data);
          bqbp_pkg::REG_COEF_A2:  a2_q   = bqbp_pkg::coef_t'(cfg_ch.data);
          bqbp_pkg::REG_COEF_B0:  b0_q   = bqbp_pkg::coef_t'(cfg_ch.data);
          bqbp_pkg::REG_OUT_GAIN: gain_q = cfg_ch.data[bqbp_pkg::GainWidth-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        nxt         = filter_step(in_ch.sample_in);
        delay_two_q = delay_one_q;
        delay_one_q = nxt.delay;
        expected_words.push_back(nxt.word);
      end
      fail_count_o <= fails;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// ===== tb/tb_biquad_bandpass_filter.sv =====
// Testbench top for the band-pass biquad: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_biquad_bandpass_filter;

  localparam bqbp_pkg::coef_t CoefMax  = 26'sh1FFFFFF;
  localparam bqbp_pkg::coef_t CoefMin  = 26'sh2000000;
  localparam bqbp_pkg::coef_t CoefUnit = 26'sd4194304;
  localparam bqbp_pkg::gain_t GainMax  = 24'hFFFFFF;
  localparam int              RunLimitNs = 50_000_000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned burst_left;
  bit          random_started;

  bqbp_in_if  in_ch ();
  bqbp_out_if out_ch ();
  bqbp_cfg_if cfg_ch ();

  biquad_bandpass_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bqbp_out_checker u_out_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("status: fail");
    $finish;
  end

  // Sender works in bursts; a gap drops valid for a random number of cycles.
  task automatic send_sample(input bqbp_pkg::sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    burst_left--;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Waits until every word has come back, then lets the sequencer settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input bqbp_pkg::cfg_reg_e idx, input bqbp_pkg::cfg_data_t d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic set_filter(input bqbp_pkg::coef_t a1, input bqbp_pkg::coef_t a2,
                            input bqbp_pkg::coef_t b0, input bqbp_pkg::gain_t g);
    write_reg(bqbp_pkg::REG_COEF_A1, bqbp_pkg::cfg_data_t'(a1));
    write_reg(bqbp_pkg::REG_COEF_A2, bqbp_pkg::cfg_data_t'(a2));
    write_reg(bqbp_pkg::REG_COEF_B0, bqbp_pkg::cfg_data_t'(b0));
    write_reg(bqbp_pkg::REG_OUT_GAIN, bqbp_pkg::cfg_data_t'(g));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic bqbp_pkg::coef_t edge_coef();
    case ($urandom_range(0, 3))
      0:       return CoefMin;
      1:       return CoefMax;
      2:       return '0;
      default: return -26'sd1;
    endcase
  endfunction

  // Receiver: random stall patterns, with a long hold-off early in the random part and more at random after it.
  initial begin
    int unsigned mode;
    int unsigned len;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(20, 200);
      if ((random_started && !long_hold_done) || (mode == 0 && random_started)) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(200, 400)) @(posedge clk_i);
      end else begin
        for (int i = 0; i < len; i++) begin
          if (mode <= 3)
            out_ch.ready <= 1'b1;
          else if (mode <= 6)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          else
            out_ch.ready <= (i % 3 != 0);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int unsigned       n_items;
    int unsigned       kind;
    int unsigned       amp_shift;
    int                lim;
    int                a2_i;
    bqbp_pkg::coef_t   a1;
    bqbp_pkg::coef_t   a2;
    bqbp_pkg::coef_t   b0;
    bqbp_pkg::gain_t   g;
    bqbp_pkg::sample_t s;
    burst_left     = 0;
    random_started = 1'b0;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.sample_in  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= bqbp_pkg::REG_COEF_A1;
    cfg_ch.data      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Plain difference x - x[n-2]: field extremes and output saturation.
    set_filter('0, '0, CoefUnit, bqbp_pkg::GainReset);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample('0);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    drain();

    // Strongly unstable feedback drives the delay values into saturation.
    set_filter(CoefMin, CoefMax, CoefMax, GainMax);
    repeat (4) send_sample(24'sh7FFFFF);
    repeat (3) send_sample(24'sh800000);
    drain();

    // Zero gain: the output is silent while the delays may still clip.
    set_filter(CoefMax, CoefMin, CoefMin, '0);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    drain();

    random_started = 1'b1;
    for (int phase = 0; phase < 12; phase++) begin
      kind = $urandom_range(0, 5);
      if (kind <= 2) begin
        // Stable resonator: a2 in 0.5..0.99 and |a1| below 1 + a2.
        a2_i = $urandom_range(2097152, 4152360);
        lim  = 4194304 + a2_i - 1;
        a1   = bqbp_pkg::coef_t'(int'($urandom_range(0, 2 * lim)) - lim);
        a2   = bqbp_pkg::coef_t'(a2_i);
        b0   = bqbp_pkg::coef_t'((4194304 - a2_i) / 2);
        g    = (kind == 0) ? bqbp_pkg::GainReset
                           : bqbp_pkg::gain_t'($urandom_range(262144, 4194304));
      end else if (kind == 3) begin
        a1 = bqbp_pkg::coef_t'(int'($urandom_range(0, 2097152)) - 1048576);
        a2 = bqbp_pkg::coef_t'(int'($urandom_range(0, 2097152)) - 1048576);
        b0 = bqbp_pkg::coef_t'($urandom());
        g  = bqbp_pkg::gain_t'($urandom_range(0, 2097152));
      end else if (kind == 4) begin
        a1 = bqbp_pkg::coef_t'($urandom());
        a2 = bqbp_pkg::coef_t'($urandom());
        b0 = bqbp_pkg::coef_t'($urandom());
        g  = bqbp_pkg::gain_t'($urandom());
      end else begin
        a1 = edge_coef();
        a2 = edge_coef();
        b0 = edge_coef();
        case ($urandom_range(0, 2))
          0:       g = '0;
          1:       g = GainMax;
          default: g = bqbp_pkg::GainReset;
        endcase
      end
      set_filter(a1, a2, b0, g);
      amp_shift = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      n_items   = $urandom_range(100, 200);
      for (int k = 0; k < n_items; k++) begin
        s = bqbp_pkg::sample_t'($urandom());
        s = s >>> amp_shift;
        if ($urandom_range(0, 15) == 0)
          s = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
        send_sample(s);
      end
      drain();
    end

    if (fail_count == 0 && pending_words == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
